FILE: hdl/qtd_pkg.sv
// shared types and constants for the binary128 to binary64 converter
package qtd_pkg;
    localparam int unsigned QEXP_W = 15;
    localparam logic [QEXP_W-1:0] QEXP_ALL_ONES = 15'h7fff;
    localparam int QEXP_BIAS = 16383;
    localparam int DEXP_BIAS = 1023;
    localparam int DEXP_MIN = -1022;
    localparam int BASE_SHIFT = 60;
    localparam int MAX_SHIFT = 113;
    localparam logic [63:0] QNAN_BITS = 64'h7ff8000000000000;
    localparam logic [63:0] INF_BITS = 64'h7ff0000000000000;

    // special-case kinds decided in the first stage
    typedef enum logic [1:0] {
        K_NORM = 2'd0,
        K_ZERO = 2'd1,
        K_INF  = 2'd2,
        K_NAN  = 2'd3
    } t_kind;

    // stage 1 to stage 2: decoded operand
    typedef struct packed {
        logic         sign;
        t_kind        kind;
        logic [6:0]   shift;     // 60..113
        logic [11:0]  biased;    // pre-round biased exponent, 1..2047
        logic [112:0] sig;
    } t_dec;

    // stage 2 to stage 3: aligned significand with rounding bits
    typedef struct packed {
        logic         sign;
        t_kind        kind;
        logic [11:0]  biased;
        logic [52:0]  mant;
        logic         rnd;
        logic         sticky;
    } t_aln;
endpackage

FILE: hdl/qtd_stream_if.sv
// valid/ready stream interface
interface qtd_stream_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [63:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/qtd_stage.sv
// one pipeline register stage with valid and stall
module qtd_stage_dec (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [63:0]   i_hi,
    input  logic [63:0]   i_lo,
    output logic          o_valid,
    output qtd_pkg::t_dec o_dec
);
    logic [14:0] w_exp;
    logic [15:0] w_deficit;
    logic signed [16:0] w_biased_full;
    qtd_pkg::t_dec n_dec;
    qtd_pkg::t_dec r_dec;
    logic          r_valid;

    // decode exponent and pick the alignment shift
    always_comb begin
        w_exp = i_hi[62:48];
        w_deficit = 16'd0;
        w_biased_full = 17'(int'(w_exp) - qtd_pkg::QEXP_BIAS + qtd_pkg::DEXP_BIAS);
        n_dec.sign = i_hi[63];
        n_dec.sig = {1'b1, i_hi[47:0], i_lo};
        n_dec.shift = 7'(qtd_pkg::BASE_SHIFT);
        // exponents far above the binary64 range saturate to the overflow code
        n_dec.biased = (w_biased_full > 17'sd2047) ? 12'h7ff : w_biased_full[11:0];
        n_dec.kind = qtd_pkg::K_NORM;
        if (w_exp == qtd_pkg::QEXP_ALL_ONES) begin
            n_dec.kind = (i_hi[47:0] != '0 || i_lo != '0) ? qtd_pkg::K_NAN : qtd_pkg::K_INF;
        end else if (w_exp == '0) begin
            n_dec.kind = qtd_pkg::K_ZERO;
        end else if (int'(w_exp) - qtd_pkg::QEXP_BIAS < qtd_pkg::DEXP_MIN) begin
            w_deficit = 16'(qtd_pkg::DEXP_MIN + qtd_pkg::QEXP_BIAS - int'(w_exp));
            n_dec.biased = 12'd1;
            if (w_deficit > 16'(qtd_pkg::MAX_SHIFT - qtd_pkg::BASE_SHIFT))
                n_dec.kind = qtd_pkg::K_ZERO;
            else
                n_dec.shift = 7'(qtd_pkg::BASE_SHIFT) + w_deficit[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec = r_dec;
endmodule

FILE: hdl/qtd_align.sv
// stage 2: shift significand right and collect round and sticky bits
module qtd_align (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  qtd_pkg::t_dec i_dec,
    output logic          o_valid,
    output qtd_pkg::t_aln o_aln
);
    logic [113:0] w_ext;
    logic [113:0] w_shr;
    logic [113:0] w_mask;
    qtd_pkg::t_aln n_aln;
    qtd_pkg::t_aln r_aln;
    logic          r_valid;

    // shift by one less than needed so the round bit lands at bit 0
    always_comb begin
        w_ext = {1'b0, i_dec.sig};
        w_shr = w_ext >> (i_dec.shift - 7'd1);
        w_mask = ~({114{1'b1}} << (i_dec.shift - 7'd1));
        n_aln.sign = i_dec.sign;
        n_aln.kind = i_dec.kind;
        n_aln.biased = i_dec.biased;
        n_aln.mant = w_shr[53:1];
        n_aln.rnd = w_shr[0];
        n_aln.sticky = (w_ext & w_mask) != '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_aln <= n_aln;
        end
    end

    assign o_valid = r_valid;
    assign o_aln = r_aln;
endmodule

FILE: hdl/qtd_round.sv
// stage 3: round to nearest even, renormalize and pack
module qtd_round (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  qtd_pkg::t_aln i_aln,
    output logic          o_valid,
    output logic [63:0]   o_bits
);
    logic [53:0] w_mant;
    logic [11:0] w_biased;
    logic [63:0] n_bits;
    logic [63:0] r_bits;
    logic        r_valid;

    always_comb begin
        w_mant = {1'b0, i_aln.mant};
        if (i_aln.rnd && (i_aln.sticky || i_aln.mant[0]))
            w_mant = w_mant + 54'd1;
        w_biased = i_aln.biased;
        // carry out of the significand
        if (w_mant[53]) begin
            w_mant = w_mant >> 1;
            w_biased = w_biased + 12'd1;
        end
        if (!w_mant[52])
            w_biased = '0;
        case (i_aln.kind)
            qtd_pkg::K_NAN:  n_bits = {i_aln.sign, 63'b0} | qtd_pkg::QNAN_BITS;
            qtd_pkg::K_INF:  n_bits = {i_aln.sign, 63'b0} | qtd_pkg::INF_BITS;
            qtd_pkg::K_ZERO: n_bits = {i_aln.sign, 63'b0};
            default: begin
                if (w_biased >= 12'h7ff)
                    n_bits = {i_aln.sign, 63'b0} | qtd_pkg::INF_BITS;
                else
                    n_bits = {i_aln.sign, w_biased[10:0], w_mant[51:0]};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_bits <= n_bits;
        end
    end

    assign o_valid = r_valid;
    assign o_bits = r_bits;
endmodule

FILE: hdl/quad_to_double_narrowing.sv
// top level: binary128 to binary64 narrowing conversion pipeline
// Converts a binary128 value (high word, low word) to the nearest binary64 bit pattern,
// round to nearest even, with subnormal outputs, signed infinity on overflow, quiet NaN
// with sign kept, and binary128 subnormals flushed to signed zero. Three register stages
// (decode, align shift, round and pack) accept one transfer every cycle; a stall on the
// output holds all stages in place.
module quad_to_double_narrowing (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qtd_stream_if.sink    i_in_hi,
    qtd_stream_if.sink    i_in_lo,
    qtd_stream_if.source  o_out
);
    logic          w_en;
    logic          w_in_valid;
    logic          w_v1;
    logic          w_v2;
    qtd_pkg::t_dec w_dec;
    qtd_pkg::t_aln w_aln;

    // pipeline advances unless a valid result is waiting
    assign w_en = o_out.ready || !o_out.valid;
    assign w_in_valid = i_in_hi.valid && i_in_lo.valid;
    assign i_in_hi.ready = w_en && i_in_lo.valid;
    assign i_in_lo.ready = w_en && i_in_hi.valid;

    qtd_stage_dec u_dec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_in_valid),
        .i_hi(i_in_hi.data), .i_lo(i_in_lo.data), .o_valid(w_v1), .o_dec(w_dec)
    );
    qtd_align u_aln (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_v1),
        .i_dec(w_dec), .o_valid(w_v2), .o_aln(w_aln)
    );
    qtd_round u_rnd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_v2),
        .i_aln(w_aln), .o_valid(o_out.valid), .o_bits(o_out.data)
    );
endmodule

FILE: hdl/qtd_checker.sv
// port-level assertions for the converter, bound to the top level
module qtd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_hi_valid,
    input logic        i_hi_ready,
    input logic        i_lo_valid,
    input logic        i_lo_ready,
    input logic        o_valid,
    input logic        o_ready,
    input logic [63:0] o_data
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_data)) else $error("result dropped");
    // both input words move together
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_hi_valid && i_hi_ready) == (i_lo_valid && i_lo_ready)) else $error("split input");
    // an accepted pair reaches the output when the output is never stalled
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hi_valid && i_hi_ready && o_ready ##1 o_ready ##1 o_ready |=> o_valid)
        else $error("result missing");
    // no result out of reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind quad_to_double_narrowing qtd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_hi_valid(i_in_hi.valid), .i_hi_ready(i_in_hi.ready),
    .i_lo_valid(i_in_lo.valid), .i_lo_ready(i_in_lo.ready),
    .o_valid(o_out.valid), .o_ready(o_out.ready), .o_data(o_out.data)
);
